// File: rtl/core/avsm_pkg.sv
// Package for the aligned value scan matcher: register indexes, queue entry type
// and the IEEE compare helpers. No dependencies.
package avsm_pkg;

  localparam int CFG_DATA_W = 64;

  typedef enum logic [2:0] {
    REG_TARGET    = 3'd0,
    REG_LENGTH    = 3'd1,
    REG_STRIDE    = 3'd2,
    REG_FLOAT     = 3'd3,
    REG_LOW_BOUND = 3'd4,
    REG_HIGH_BOUND = 3'd5
  } reg_index_t;

  // One classified request that the front hands to the back.
  typedef struct packed {
    logic [63:0] cand;
    logic [31:0] offset;
    logic        tested;
    logic        last;
  } scan_item_t;

  // Strict a < b on IEEE bit patterns with the sign held in the top bit.
  // NaN operands are screened by the caller.
  function automatic logic fp_less64(input logic [63:0] a, input logic [63:0] b);
    logic a_zero_both;
    logic res;
    a_zero_both = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    if (a_zero_both) res = 1'b0;
    else if (a[63] != b[63]) res = a[63];
    else if (!a[63]) res = a[62:0] < b[62:0];
    else res = a[62:0] > b[62:0];
    return res;
  endfunction

  function automatic logic fp_less32(input logic [31:0] a, input logic [31:0] b);
    logic res;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) res = 1'b0;
    else if (a[31] != b[31]) res = a[31];
    else if (!a[31]) res = a[30:0] < b[30:0];
    else res = a[30:0] > b[30:0];
    return res;
  endfunction

  function automatic logic is_nan64(input logic [63:0] a);
    return (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
  endfunction

  function automatic logic is_nan32(input logic [31:0] a);
    return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
  endfunction

endpackage

// File: rtl/core/avsm_front.sv
// Front end: shifts bytes into the window, tracks offset and stride phase and
// marks aligned complete windows. Depends on avsm_pkg.
module avsm_front #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic [3:0]           width_bytes,
  input  logic [6:0]           stride_eff,
  output avsm_pkg::scan_item_t item
);

  logic [63:0]            byte_window;
  logic [OFFSET_BITS-1:0] byte_count;
  logic [5:0]             stride_phase;
  logic [7:0]             aligned_marks;
  logic [63:0]            window_next;
  logic [7:0]             marks_next;
  logic [OFFSET_BITS-1:0] start_off;
  logic [6:0]             phase_inc;
  logic                   tested;

  assign window_next = {data_byte, byte_window[63:8]};
  assign marks_next  = {(stride_phase == 6'd0), aligned_marks[7:1]};
  assign phase_inc   = {1'b0, stride_phase} + 7'd1;

  always_comb begin
    tested = 1'b0;
    case (width_bytes)
      4'd1:    tested = marks_next[7];
      4'd2:    tested = marks_next[6];
      4'd4:    tested = marks_next[4];
      default: tested = marks_next[0];
    endcase
  end

  assign start_off = byte_count - OFFSET_BITS'(width_bytes - 4'd1);

  always_comb begin
    item.cand   = window_next;
    item.tested = tested;
    item.last   = last_byte;
    item.offset = 32'(start_off);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_window   <= '0;
      byte_count    <= '0;
      stride_phase  <= '0;
      aligned_marks <= '0;
    end else if (take) begin
      byte_window <= window_next;
      if (last_byte) begin
        byte_count    <= '0;
        stride_phase  <= '0;
        aligned_marks <= '0;
      end else begin
        byte_count    <= byte_count + OFFSET_BITS'(1);
        aligned_marks <= marks_next;
        stride_phase  <= (phase_inc >= stride_eff) ? 6'd0 : phase_inc[5:0];
      end
    end
  end

endmodule

// File: rtl/core/avsm_queue.sv
// Two-entry queue between front and back so each side can stall alone.
// Depends on avsm_pkg.
module avsm_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  avsm_pkg::scan_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 nonempty,
  output avsm_pkg::scan_item_t head
);

  avsm_pkg::scan_item_t slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;

  assign full     = fill == 2'd2;
  assign nonempty = fill != 2'd0;
  assign head     = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/core/avsm_back.sv
// Back end: runs the integer and float tests on a queued window and holds the
// result in an output register. Depends on avsm_pkg.
module avsm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 have_item,
  input  avsm_pkg::scan_item_t item,
  output logic                 pop,
  input  logic [63:0]          target_value,
  input  logic [3:0]           len_eff,
  input  logic [3:0]           width_bytes,
  input  logic                 float_mode,
  input  logic [63:0]          low_bound,
  input  logic [63:0]          high_bound,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          match_offset,
  output logic                 is_match,
  output logic                 scan_done
);

  logic [63:0] cand;
  logic [63:0] wmask;
  logic [63:0] lmask;
  logic        int_hit;
  logic        flt_hit;
  logic        hit;
  logic        emit;
  logic        slot_free;

  always_comb begin
    case (width_bytes)
      4'd1:    cand = {56'd0, item.cand[63:56]};
      4'd2:    cand = {48'd0, item.cand[63:48]};
      4'd4:    cand = {32'd0, item.cand[63:32]};
      default: cand = item.cand;
    endcase
    wmask = (width_bytes >= 4'd8) ? '1 : ((64'd1 << {width_bytes, 3'd0}) - 64'd1);
    lmask = (len_eff >= 4'd8) ? '1 : ((64'd1 << {len_eff, 3'd0}) - 64'd1);
  end

  assign int_hit = (cand & wmask) == (target_value & lmask);

  always_comb begin
    flt_hit = 1'b0;
    if (float_mode && len_eff == 4'd4) begin
      flt_hit = !avsm_pkg::is_nan32(cand[31:0]) && !avsm_pkg::is_nan32(low_bound[31:0])
             && !avsm_pkg::is_nan32(high_bound[31:0])
             && avsm_pkg::fp_less32(low_bound[31:0], cand[31:0])
             && avsm_pkg::fp_less32(cand[31:0], high_bound[31:0]);
    end else if (float_mode && len_eff == 4'd8) begin
      flt_hit = !avsm_pkg::is_nan64(cand) && !avsm_pkg::is_nan64(low_bound)
             && !avsm_pkg::is_nan64(high_bound)
             && avsm_pkg::fp_less64(low_bound, cand)
             && avsm_pkg::fp_less64(cand, high_bound);
    end
  end

  assign hit       = item.tested && (int_hit || flt_hit);
  assign emit      = hit || item.last;
  assign slot_free = !out_valid || !out_stall;
  // A request with no result drains freely; one with a result needs the slot.
  assign pop       = have_item && (!emit || slot_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= have_item && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && have_item && emit) begin
      match_offset <= hit ? item.offset : 32'd0;
      is_match     <= hit;
      scan_done    <= item.last;
    end
  end

endmodule

// File: rtl/core/aligned_value_scan_matcher_core.sv
// Aligned value scan matcher top level: registers, front, queue and back.
// Throughput one byte per cycle while in_stall is low. A byte's window is pushed into
// the queue, and its result is registered in the output register when the back pops it.
// A stalled result holds the queue, and the input stalls once the two queue entries are taken.
// Reset (rst, synchronous) clears window, counters, queue and output valid and
// loads the register reset values. Depends on avsm_pkg, avsm_front, avsm_queue, avsm_back.
module aligned_value_scan_matcher_core #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] match_offset,
  output logic        is_match,
  output logic        scan_done
);

  logic [63:0] target_value;
  logic [3:0]  search_len;
  logic [6:0]  stride;
  logic        float_mode;
  logic [63:0] low_bound;
  logic [63:0] high_bound;
  logic [3:0]  len_eff;
  logic [3:0]  width_bytes;
  logic [6:0]  stride_eff;
  logic        take;
  logic        q_full;
  logic        q_nonempty;
  logic        q_pop;
  avsm_pkg::scan_item_t front_item;
  avsm_pkg::scan_item_t head_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_value <= '0;
      search_len   <= 4'd4;
      stride       <= 7'd1;
      float_mode   <= 1'b0;
      low_bound    <= '0;
      high_bound   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        avsm_pkg::REG_TARGET:     target_value <= cfg_data;
        avsm_pkg::REG_LENGTH:     search_len   <= cfg_data[3:0];
        avsm_pkg::REG_STRIDE:     stride       <= cfg_data[6:0];
        avsm_pkg::REG_FLOAT:      float_mode   <= cfg_data[0];
        avsm_pkg::REG_LOW_BOUND:  low_bound    <= cfg_data;
        avsm_pkg::REG_HIGH_BOUND: high_bound   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff = search_len;
    if (search_len == 4'd0) len_eff = 4'd1;
    if (search_len > 4'd8) len_eff = 4'd8;
    stride_eff = stride;
    if (stride == 7'd0) stride_eff = 7'd1;
    if (stride > 7'd64) stride_eff = 7'd64;
    if (len_eff <= 4'd1) width_bytes = 4'd1;
    else if (len_eff <= 4'd2) width_bytes = 4'd2;
    else if (len_eff <= 4'd4) width_bytes = 4'd4;
    else width_bytes = 4'd8;
  end

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  avsm_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk, .rst, .take, .data_byte, .last_byte,
    .width_bytes, .stride_eff, .item(front_item)
  );

  avsm_queue u_queue (
    .clk, .rst, .push(take), .push_item(front_item), .full(q_full),
    .pop(q_pop), .nonempty(q_nonempty), .head(head_item)
  );

  avsm_back u_back (
    .clk, .rst, .have_item(q_nonempty), .item(head_item), .pop(q_pop),
    .target_value, .len_eff, .width_bytes, .float_mode, .low_bound, .high_bound,
    .out_valid, .out_stall, .match_offset, .is_match, .scan_done
  );

endmodule

// File: rtl/core/avsm_checker.sv
// Port-level checker for the scan matcher, bound to the top level.
// Depends only on the top level's ports.
module avsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] match_offset,
  input logic        is_match,
  input logic        scan_done
);

  // Every result carries a match or marks the end of the image.
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_match || scan_done)) else $error("empty result");

  // A non-match result reports offset zero.
  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_match) |-> (match_offset == 32'd0)) else $error("stray offset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(match_offset)
      && $stable(is_match) && $stable(scan_done))) else $error("result dropped");

  // Nothing comes out of a block that was just reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("output after reset");

  // A block that was just reset takes requests.
  a_reset_ready: assert property (@(posedge clk)
    rst |=> !in_stall) else $error("input stalled after reset");

endmodule

bind aligned_value_scan_matcher_core avsm_checker u_avsm_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall,
  .match_offset, .is_match, .scan_done
);
